// File: rtl/core/tfn_pkg.sv
// Shared constants and types for the triangle face normal unit.
// No dependencies; every rtl/core module refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  localparam int INDEX_BITS = 24;
  localparam int COORD_BITS = 32;
  localparam int NORM_BITS  = 31;
  localparam int NORM_ONE   = 16384;
  localparam int Q_BITS     = 15;
  localparam int SUM_BITS   = 2 * NORM_BITS + 2;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int NUM_BITS   = NORM_BITS + Q_BITS + 1;
  localparam int DEN_BITS   = ROOT_BITS + 1;
  localparam int OUT_BITS   = 16;

  typedef struct packed {
    logic en;
    logic vld;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/tfn_cross.sv
// Edge subtract, six products, cross difference and magnitude split (4 stages).
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_cross #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS,
  parameter int SIDE_W     = 1
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire tfn_pkg::ctl_t            ctl,
  input  wire logic signed [COORD_BITS-1:0] a_x,
  input  wire logic signed [COORD_BITS-1:0] a_y,
  input  wire logic signed [COORD_BITS-1:0] a_z,
  input  wire logic signed [COORD_BITS-1:0] b_x,
  input  wire logic signed [COORD_BITS-1:0] b_y,
  input  wire logic signed [COORD_BITS-1:0] b_z,
  input  wire logic signed [COORD_BITS-1:0] c_x,
  input  wire logic signed [COORD_BITS-1:0] c_y,
  input  wire logic signed [COORD_BITS-1:0] c_z,
  input  wire logic [SIDE_W-1:0]        side_in,
  output logic                          vld_out,
  output logic [2*COORD_BITS+2:0]       mag_x,
  output logic [2*COORD_BITS+2:0]       mag_y,
  output logic [2*COORD_BITS+2:0]       mag_z,
  output logic [2:0]                    neg,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int E = COORD_BITS + 1;
  localparam int P = 2 * E;
  localparam int X = 2 * COORD_BITS + 3;

  logic signed [E-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [P-1:0] pyz, pzy, pzx, pxz, pxy, pyx;
  logic signed [X-1:0] cx, cy, cz;
  logic [3:0]          vld;
  logic [SIDE_W-1:0]   sd [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      e1x <= E'(b_x) - E'(a_x);
      e1y <= E'(b_y) - E'(a_y);
      e1z <= E'(b_z) - E'(a_z);
      e2x <= E'(c_x) - E'(a_x);
      e2y <= E'(c_y) - E'(a_y);
      e2z <= E'(c_z) - E'(a_z);
      pyz <= e1y * e2z;
      pzy <= e1z * e2y;
      pzx <= e1z * e2x;
      pxz <= e1x * e2z;
      pxy <= e1x * e2y;
      pyx <= e1y * e2x;
      cx  <= X'(pyz) - X'(pzy);
      cy  <= X'(pzx) - X'(pxz);
      cz  <= X'(pxy) - X'(pyx);
      neg   <= {cz[X-1], cy[X-1], cx[X-1]};
      mag_x <= cx[X-1] ? X'(-cx) : X'(cx);
      mag_y <= cy[X-1] ? X'(-cy) : X'(cy);
      mag_z <= cz[X-1] ? X'(-cz) : X'(cz);
      sd[0] <= side_in;
      for (int k = 1; k < 4; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  assign vld_out  = vld[3];
  assign side_out = sd[3];

endmodule

`default_nettype wire

// File: rtl/core/tfn_norm.sv
// Leading-zero search, common shift to 31 bits, squares and their sum (5 stages).
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_norm #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS,
  parameter int SIDE_W     = 1
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire tfn_pkg::ctl_t              ctl,
  input  wire logic [2*COORD_BITS+2:0]    mag_x,
  input  wire logic [2*COORD_BITS+2:0]    mag_y,
  input  wire logic [2*COORD_BITS+2:0]    mag_z,
  input  wire logic [SIDE_W-1:0]          side_in,
  output logic                            vld_out,
  output logic [tfn_pkg::NORM_BITS-1:0]   v_x,
  output logic [tfn_pkg::NORM_BITS-1:0]   v_y,
  output logic [tfn_pkg::NORM_BITS-1:0]   v_z,
  output logic [tfn_pkg::SUM_BITS-1:0]    sum,
  output logic                            degen,
  output logic [SIDE_W-1:0]               side_out
);

  localparam int X   = 2 * COORD_BITS + 3;
  localparam int G   = (X + 7) / 8;
  localparam int XP  = G * 8;
  localparam int LZW = $clog2(XP + 1);
  localparam int NB  = tfn_pkg::NORM_BITS;
  localparam int SB  = tfn_pkg::SUM_BITS;

  logic [XP-1:0]    p1x, p1y, p1z, p2x, p2y, p2z;
  logic [G-1:0]     nz1;
  logic [2:0]       glz1 [G];
  logic [LZW-1:0]   lz2;
  logic             dg2, dg3, dg4;
  logic [NB-1:0]    v3x, v3y, v3z, v4x, v4y, v4z;
  logic [2*NB-1:0]  sqx, sqy, sqz;
  logic [4:0]       vld;
  logic [SIDE_W-1:0] sd [5];

  logic [XP-1:0]    orw;
  logic [G-1:0]     nz_next;
  logic [2:0]       glz_next [G];
  logic [LZW-1:0]   lz_next;
  logic [XP-1:0]    shx, shy, shz;

  always_comb begin
    logic [7:0] grp;
    orw = {mag_x | mag_y | mag_z, (XP-X)'(0)};
    for (int g = 0; g < G; g++) begin
      grp = orw[XP-1-8*g -: 8];
      nz_next[g] = |grp;
      glz_next[g] = 3'd0;
      for (int j = 0; j < 8; j++) begin
        if (grp[j]) begin
          glz_next[g] = 3'(7 - j);
        end
      end
    end
  end

  always_comb begin
    logic found;
    found = 1'b0;
    lz_next = '0;
    for (int g = 0; g < G; g++) begin
      if (!found && nz1[g]) begin
        lz_next = LZW'(8 * g) + LZW'(glz1[g]);
        found = 1'b1;
      end
    end
  end

  assign shx = p2x << lz2;
  assign shy = p2y << lz2;
  assign shz = p2z << lz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[3:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p1x <= {mag_x, (XP-X)'(0)};
      p1y <= {mag_y, (XP-X)'(0)};
      p1z <= {mag_z, (XP-X)'(0)};
      nz1 <= nz_next;
      for (int g = 0; g < G; g++) begin
        glz1[g] <= glz_next[g];
      end
      p2x <= p1x;
      p2y <= p1y;
      p2z <= p1z;
      lz2 <= lz_next;
      dg2 <= ~|nz1;
      v3x <= shx[XP-1 -: NB];
      v3y <= shy[XP-1 -: NB];
      v3z <= shz[XP-1 -: NB];
      dg3 <= dg2;
      sqx <= v3x * v3x;
      sqy <= v3y * v3y;
      sqz <= v3z * v3z;
      v4x <= v3x;
      v4y <= v3y;
      v4z <= v3z;
      dg4 <= dg3;
      sum <= SB'(sqx) + SB'(sqy) + SB'(sqz);
      v_x <= v4x;
      v_y <= v4y;
      v_z <= v4z;
      degen <= dg4;
      sd[0] <= side_in;
      for (int k = 1; k < 5; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  assign vld_out  = vld[4];
  assign side_out = sd[4];

endmodule

`default_nettype wire

// File: rtl/core/tfn_isqrt.sv
// Integer square root, one result bit per stage (ROOT_BITS stages).
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_isqrt #(
  parameter int SIDE_W = 1
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire tfn_pkg::ctl_t             ctl,
  input  wire logic [tfn_pkg::SUM_BITS-1:0] sum,
  input  wire logic [SIDE_W-1:0]         side_in,
  output logic                           vld_out,
  output logic [tfn_pkg::ROOT_BITS-1:0]  root,
  output logic [SIDE_W-1:0]              side_out
);

  localparam int RB = tfn_pkg::ROOT_BITS;
  localparam int SB = tfn_pkg::SUM_BITS;

  logic [SB-1:0]     rem_q  [RB];
  logic [RB-1:0]     root_q [RB];
  logic [RB-1:0]     vld_q;
  logic [SIDE_W-1:0] sd_q   [RB];

  for (genvar k = 0; k < RB; k++) begin : g_st
    logic [SB-1:0]     rin;
    logic [RB-1:0]     qin;
    logic              vin;
    logic [SIDE_W-1:0] sin;
    logic [SB:0]       trial;

    if (k == 0) begin : g_first
      assign rin = sum;
      assign qin = '0;
      assign vin = ctl.vld;
      assign sin = side_in;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
      assign vin = vld_q[k-1];
      assign sin = sd_q[k-1];
    end

    assign trial = ((SB+1)'(qin) << (RB - k)) + ((SB+1)'(1) << (2 * (RB - 1 - k)));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if ((SB+1)'(rin) >= trial) begin
          rem_q[k]  <= SB'((SB+1)'(rin) - trial);
          root_q[k] <= qin | (RB'(1) << (RB - 1 - k));
        end else begin
          rem_q[k]  <= rin;
          root_q[k] <= qin;
        end
        sd_q[k] <= sin;
      end
    end
  end

  assign vld_out  = vld_q[RB-1];
  assign root     = root_q[RB-1];
  assign side_out = sd_q[RB-1];

endmodule

`default_nettype wire

// File: rtl/core/tfn_div.sv
// Rounded quotient v*16384/len for three lanes: setup stage plus Q_BITS restoring stages.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_div #(
  parameter int SIDE_W = 1
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire tfn_pkg::ctl_t              ctl,
  input  wire logic [tfn_pkg::NORM_BITS-1:0] v_x,
  input  wire logic [tfn_pkg::NORM_BITS-1:0] v_y,
  input  wire logic [tfn_pkg::NORM_BITS-1:0] v_z,
  input  wire logic [tfn_pkg::ROOT_BITS-1:0] len,
  input  wire logic [SIDE_W-1:0]          side_in,
  output logic                            vld_out,
  output logic [tfn_pkg::Q_BITS-1:0]      q_x,
  output logic [tfn_pkg::Q_BITS-1:0]      q_y,
  output logic [tfn_pkg::Q_BITS-1:0]      q_z,
  output logic [SIDE_W-1:0]               side_out
);

  localparam int QB = tfn_pkg::Q_BITS;
  localparam int NW = tfn_pkg::NUM_BITS;
  localparam int DW = tfn_pkg::DEN_BITS;
  localparam int RB = tfn_pkg::ROOT_BITS;

  logic [NW-1:0]     rem_q [QB+1][3];
  logic [QB-1:0]     quo_q [QB+1][3];
  logic [DW-1:0]     den_q [QB+1];
  logic [QB:0]       vld_q;
  logic [SIDE_W-1:0] sd_q  [QB+1];

  logic [RB-1:0]     len_fix;
  logic [NW-1:0]     vin [3];

  assign len_fix = (len == '0) ? RB'(1) : len;
  assign vin[0]  = NW'(v_x);
  assign vin[1]  = NW'(v_y);
  assign vin[2]  = NW'(v_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (ctl.en) begin
      vld_q <= {vld_q[QB-1:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= (vin[l] << (QB)) + NW'(len_fix);
        quo_q[0][l] <= '0;
      end
      den_q[0] <= {len_fix, 1'b0};
      sd_q[0]  <= side_in;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_st
    logic [NW-1:0] dsh;
    assign dsh = NW'(den_q[k-1]) << (QB - k);

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_q[k-1][l] >= dsh) begin
            rem_q[k][l] <= rem_q[k-1][l] - dsh;
            quo_q[k][l] <= quo_q[k-1][l] | (QB'(1) << (QB - k));
          end else begin
            rem_q[k][l] <= rem_q[k-1][l];
            quo_q[k][l] <= quo_q[k-1][l];
          end
        end
        den_q[k] <= den_q[k-1];
        sd_q[k]  <= sd_q[k-1];
      end
    end
  end

  assign vld_out  = vld_q[QB];
  assign q_x      = quo_q[QB][0];
  assign q_y      = quo_q[QB][1];
  assign q_z      = quo_q[QB][2];
  assign side_out = sd_q[QB];

endmodule

`default_nettype wire

// File: rtl/core/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit: cross product, normalize, output word.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_isqrt, tfn_div.
//
// Use: one triangle word enters on in_valid/in_stall (three indices, nine
// signed Q15.16 coordinates). One result word leaves on out_valid/out_stall:
// the indices, a unit normal in signed Q1.14 and a degenerate flag, set with a
// zero normal when the cross product is exactly zero.
// Throughput: one word per cycle while the receiver takes results.
// Depth: 58 register stages (4 cross stages, 5 normalize stages, 32 square
// root stages, 16 divider stages, one output register). The square root,
// one result bit per stage, sets the depth.
// Reset: synchronous rst empties the pipeline; out_valid is low after it.
// Stall: when a result waits under out_stall the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal_unit #(
  parameter int INDEX_BITS = tfn_pkg::INDEX_BITS,
  parameter int COORD_BITS = tfn_pkg::COORD_BITS
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire logic [INDEX_BITS-1:0]        index_a,
  input  wire logic [INDEX_BITS-1:0]        index_b,
  input  wire logic [INDEX_BITS-1:0]        index_c,
  input  wire logic signed [COORD_BITS-1:0] a_x,
  input  wire logic signed [COORD_BITS-1:0] a_y,
  input  wire logic signed [COORD_BITS-1:0] a_z,
  input  wire logic signed [COORD_BITS-1:0] b_x,
  input  wire logic signed [COORD_BITS-1:0] b_y,
  input  wire logic signed [COORD_BITS-1:0] b_z,
  input  wire logic signed [COORD_BITS-1:0] c_x,
  input  wire logic signed [COORD_BITS-1:0] c_y,
  input  wire logic signed [COORD_BITS-1:0] c_z,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [INDEX_BITS-1:0]             out_index_a,
  output logic [INDEX_BITS-1:0]             out_index_b,
  output logic [INDEX_BITS-1:0]             out_index_c,
  output logic signed [15:0]                normal_x,
  output logic signed [15:0]                normal_y,
  output logic signed [15:0]                normal_z,
  output logic                              degenerate
);

  localparam int X   = 2 * COORD_BITS + 3;
  localparam int NB  = tfn_pkg::NORM_BITS;
  localparam int SB  = tfn_pkg::SUM_BITS;
  localparam int RB  = tfn_pkg::ROOT_BITS;
  localparam int QB  = tfn_pkg::Q_BITS;
  localparam int OB  = tfn_pkg::OUT_BITS;
  localparam int IW  = 3 * INDEX_BITS;
  localparam int NSW = IW + 3;
  localparam int RSW = 3 * NB + 1 + NSW;
  localparam int DSW = 1 + NSW;

  logic          en;
  tfn_pkg::ctl_t c_ctl, n_ctl, r_ctl, d_ctl;

  logic           x_vld;
  logic [X-1:0]   x_mx, x_my, x_mz;
  logic [2:0]     x_neg;
  logic [IW-1:0]  x_side;

  logic           n_vld;
  logic [NB-1:0]  n_vx, n_vy, n_vz;
  logic [SB-1:0]  n_sum;
  logic           n_dg;
  logic [NSW-1:0] n_side;

  logic           r_vld;
  logic [RB-1:0]  r_root;
  logic [RSW-1:0] r_side;

  logic           d_vld;
  logic [QB-1:0]  d_qx, d_qy, d_qz;
  logic [DSW-1:0] d_side;

  logic [NB-1:0]  r_vx, r_vy, r_vz;
  logic           d_dg;
  logic [2:0]     d_neg;
  logic [IW-1:0]  d_idx;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  assign c_ctl = '{en: en, vld: in_valid};
  assign n_ctl = '{en: en, vld: x_vld};
  assign r_ctl = '{en: en, vld: n_vld};
  assign d_ctl = '{en: en, vld: r_vld};

  tfn_cross #(.COORD_BITS(COORD_BITS), .SIDE_W(IW)) u_cross (
    .clk(clk), .rst(rst), .ctl(c_ctl),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .side_in({index_a, index_b, index_c}),
    .vld_out(x_vld), .mag_x(x_mx), .mag_y(x_my), .mag_z(x_mz),
    .neg(x_neg), .side_out(x_side)
  );

  tfn_norm #(.COORD_BITS(COORD_BITS), .SIDE_W(NSW)) u_norm (
    .clk(clk), .rst(rst), .ctl(n_ctl),
    .mag_x(x_mx), .mag_y(x_my), .mag_z(x_mz),
    .side_in({x_neg, x_side}),
    .vld_out(n_vld), .v_x(n_vx), .v_y(n_vy), .v_z(n_vz),
    .sum(n_sum), .degen(n_dg), .side_out(n_side)
  );

  tfn_isqrt #(.SIDE_W(RSW)) u_isqrt (
    .clk(clk), .rst(rst), .ctl(r_ctl),
    .sum(n_sum),
    .side_in({n_vx, n_vy, n_vz, n_dg, n_side}),
    .vld_out(r_vld), .root(r_root), .side_out(r_side)
  );

  assign {r_vx, r_vy, r_vz} = r_side[RSW-1 -: 3*NB];

  tfn_div #(.SIDE_W(DSW)) u_div (
    .clk(clk), .rst(rst), .ctl(d_ctl),
    .v_x(r_vx), .v_y(r_vy), .v_z(r_vz), .len(r_root),
    .side_in(r_side[DSW-1:0]),
    .vld_out(d_vld), .q_x(d_qx), .q_y(d_qy), .q_z(d_qz), .side_out(d_side)
  );

  assign {d_dg, d_neg, d_idx} = d_side;

  function automatic logic [OB-1:0] sign_apply(input logic [QB-1:0] q, input logic n,
                                               input logic dg);
    logic [OB-1:0] m;
    m = (OB'(q) > OB'(tfn_pkg::NORM_ONE)) ? OB'(tfn_pkg::NORM_ONE) : OB'(q);
    if (dg) begin
      return '0;
    end
    return n ? OB'(-m) : m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {out_index_a, out_index_b, out_index_c} <= d_idx;
      normal_x   <= sign_apply(d_qx, d_neg[0], d_dg);
      normal_y   <= sign_apply(d_qy, d_neg[1], d_dg);
      normal_z   <= sign_apply(d_qz, d_neg[2], d_dg);
      degenerate <= d_dg;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tfn_checker.sv
// Port-level checks for the triangle face normal unit, bound to the top level.
// Depends on triangle_face_normal_unit port names and tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_checker #(
  parameter int INDEX_BITS = tfn_pkg::INDEX_BITS
) (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_stall,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire logic [INDEX_BITS-1:0]        out_index_a,
  input wire logic [INDEX_BITS-1:0]        out_index_b,
  input wire logic [INDEX_BITS-1:0]        out_index_c,
  input wire logic signed [15:0]           normal_x,
  input wire logic signed [15:0]           normal_y,
  input wire logic signed [15:0]           normal_z,
  input wire                               degenerate
);

  localparam logic signed [15:0] ONE = 16'(tfn_pkg::NORM_ONE);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped under stall");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(normal_x) && $stable(normal_y) &&
      $stable(normal_z) && $stable(out_index_a) && $stable(out_index_b) &&
      $stable(out_index_c) && $stable(degenerate))
    else $error("result word changed under stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("degenerate word with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |->
      normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE && normal_y >= -ONE &&
      normal_z <= ONE && normal_z >= -ONE &&
      (normal_x != 0 || normal_y != 0 || normal_z != 0))
    else $error("normal out of range or zero");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind triangle_face_normal_unit tfn_checker #(
  .INDEX_BITS(INDEX_BITS)
) u_tfn_checker (.*);

`default_nettype wire
